// ===== hw/rtl/xsb_pkg.sv =====
// Shared types and constants of the XOR sprite blitter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package xsb_pkg;

   localparam int IMAGE_BYTES = 32768;
   localparam int FRAME_BYTES = 131072;
   localparam int MAX_SIDE    = 64;

   localparam int IMAGE_AW = $clog2(IMAGE_BYTES);
   localparam int FRAME_AW = $clog2(FRAME_BYTES);

   localparam int FUNC_W    = 2;
   localparam int ADDR_W    = 17;
   localparam int DATA_W    = 8;
   localparam int IMG_OFS_W = 15;
   localparam int DISP_W    = 17;
   localparam int SIDE_W    = 7;
   localparam int FLIP_W    = 2;
   localparam int STRIDE_W  = 11;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(320);

   localparam logic [DATA_W-1:0] HI_MASK = 8'hF0;
   localparam logic [DATA_W-1:0] LO_MASK = 8'h0F;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_IMG_WR = 2'd0,
      FUNC_FRM_WR = 2'd1,
      FUNC_FRM_RD = 2'd2,
      FUNC_DRAW   = 2'd3
   } func_type;

   typedef struct packed {
      func_type               func;
      logic [ADDR_W-1:0]      address;
      logic [DATA_W-1:0]      data;
      logic [IMG_OFS_W-1:0]   image_offset;
      logic [DISP_W-1:0]      display_offset;
      logic [SIDE_W-1:0]      width;
      logic [SIDE_W-1:0]      pairs;
      logic [SIDE_W-1:0]      height;
      logic                   flip_x;
      logic                   flip_y;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/xsb_front.sv =====
// Front end: takes request words and turns them into queued commands.
// Depends on xsb_pkg.
`default_nettype none

module xsb_front (
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [xsb_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [xsb_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [xsb_pkg::DATA_W-1:0]     req_data,
   input  wire logic [xsb_pkg::IMG_OFS_W-1:0]  req_image_offset,
   input  wire logic [xsb_pkg::DISP_W-1:0]     req_display_offset,
   input  wire logic [xsb_pkg::SIDE_W-1:0]     req_width,
   input  wire logic [xsb_pkg::SIDE_W-1:0]     req_height,
   input  wire logic [xsb_pkg::FLIP_W-1:0]     req_flip,
   input  wire logic                           queue_full,
   output logic                                push,
   output xsb_pkg::cmd_type                    push_cmd
);

   logic [xsb_pkg::SIDE_W-1:0] width_sat;
   logic [xsb_pkg::SIDE_W-1:0] height_sat;

   // Sprite sides above the maximum are clamped to it.
   always_comb begin
      width_sat  = (int'(req_width) > xsb_pkg::MAX_SIDE) ?
                   xsb_pkg::SIDE_W'(xsb_pkg::MAX_SIDE) : req_width;
      height_sat = (int'(req_height) > xsb_pkg::MAX_SIDE) ?
                   xsb_pkg::SIDE_W'(xsb_pkg::MAX_SIDE) : req_height;
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_cmd.func           = xsb_pkg::func_type'(req_func);
      push_cmd.address        = req_address;
      push_cmd.data           = req_data;
      push_cmd.image_offset   = req_image_offset;
      push_cmd.display_offset = req_display_offset;
      push_cmd.width          = width_sat;
      push_cmd.pairs          = width_sat >> 1;
      push_cmd.height         = height_sat;
      push_cmd.flip_x         = req_flip[0];
      push_cmd.flip_y         = req_flip[1];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/xsb_queue.sv =====
// Short command queue between the front end and the draw engine.
// Depends on xsb_pkg.
`default_nettype none

module xsb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire xsb_pkg::cmd_type  push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output xsb_pkg::cmd_type       pop_cmd
);

   localparam int PTR_W = (xsb_pkg::QUEUE_DEPTH > 1) ? $clog2(xsb_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(xsb_pkg::QUEUE_DEPTH + 1);

   xsb_pkg::cmd_type  entry_ff [xsb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_W'(xsb_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(xsb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(xsb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("Command pushed into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("Command popped from an empty queue.");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("Queue count did not follow a push.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= xsb_pkg::QUEUE_DEPTH)
      else $error("Queue count beyond its depth.");

endmodule

`default_nettype wire

// ===== hw/rtl/xsb_engine.sv =====
// Back end: sprite and frame stores, the draw sequencer and the response register.
// Depends on xsb_pkg.
`default_nettype none

module xsb_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           queue_empty,
   input  wire xsb_pkg::cmd_type               pop_cmd,
   output logic                                pop,
   input  wire logic [xsb_pkg::STRIDE_W-1:0]   row_stride,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [xsb_pkg::DATA_W-1:0]          rsp_read_data
);

   localparam int IAW  = xsb_pkg::IMAGE_AW;
   localparam int FAW  = xsb_pkg::FRAME_AW;
   localparam int SW   = xsb_pkg::SIDE_W;
   localparam int DW   = xsb_pkg::DATA_W;
   localparam int PROD_W = xsb_pkg::STRIDE_W + xsb_pkg::SIDE_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PREP,
      ST_BASE,
      ST_IMG,
      ST_RD_HI,
      ST_WR_HI,
      ST_RD_LO,
      ST_WR_LO,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]     rsp_data_ff, rsp_data_in;

   xsb_pkg::cmd_type  cmd_ff, cmd_in;
   logic [FAW-1:0]    yoff_ff, yoff_in;
   logic [FAW-1:0]    row_base_ff, row_base_in;
   logic [FAW-1:0]    pix_ff, pix_in;
   logic [IAW-1:0]    src_ff, src_in;
   logic [SW-1:0]     row_cnt_ff, row_cnt_in;
   logic [SW-1:0]     col_cnt_ff, col_cnt_in;

   logic [DW-1:0]     img_mem [xsb_pkg::IMAGE_BYTES];
   logic [DW-1:0]     frm_mem [xsb_pkg::FRAME_BYTES];
   logic [DW-1:0]     img_rd_ff;
   logic [DW-1:0]     frm_rd_ff;

   logic              img_we, img_re;
   logic [IAW-1:0]    img_addr;
   logic [DW-1:0]     img_wdata;
   logic              frm_we, frm_re;
   logic [FAW-1:0]    frm_addr;
   logic [DW-1:0]     frm_wdata;

   logic [PROD_W-1:0] yoff_prod;
   logic [FAW-1:0]    stride_ext;
   logic [FAW-1:0]    xoff;
   logic [FAW-1:0]    pix_step;
   logic [FAW-1:0]    next_base;
   logic [DW-1:0]     hi_nib, lo_nib;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   always_comb begin
      yoff_prod  = PROD_W'(row_stride) * PROD_W'(cmd_ff.height - 1'b1);
      stride_ext = FAW'(row_stride);
      xoff       = cmd_ff.flip_x ? FAW'(cmd_ff.width - 1'b1) : '0;
      pix_step   = cmd_ff.flip_x ? {FAW{1'b1}} : FAW'(1);
      next_base  = cmd_ff.flip_y ? (row_base_ff - stride_ext) : (row_base_ff + stride_ext);
      hi_nib     = img_rd_ff & xsb_pkg::HI_MASK;
      lo_nib     = (img_rd_ff & xsb_pkg::LO_MASK) << 4;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd_in       = cmd_ff;
      yoff_in      = yoff_ff;
      row_base_in  = row_base_ff;
      pix_in       = pix_ff;
      src_in       = src_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      pop          = 1'b0;
      img_we       = 1'b0;
      img_re       = 1'b0;
      img_addr     = src_ff;
      img_wdata    = cmd_ff.data;
      frm_we       = 1'b0;
      frm_re       = 1'b0;
      frm_addr     = pix_ff;
      frm_wdata    = cmd_ff.data;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               cmd_in = pop_cmd;
               state_in = (pop_cmd.func == xsb_pkg::FUNC_DRAW) ? ST_PREP : ST_EXEC;
            end
         end
         ST_EXEC: begin
            img_addr = IAW'(cmd_ff.address);
            frm_addr = FAW'(cmd_ff.address);
            unique case (cmd_ff.func)
               xsb_pkg::FUNC_IMG_WR: img_we = 1'b1;
               xsb_pkg::FUNC_FRM_WR: frm_we = 1'b1;
               xsb_pkg::FUNC_FRM_RD: frm_re = 1'b1;
               default: ;
            endcase
            state_in = ST_FINISH;
         end
         ST_PREP: begin
            yoff_in    = cmd_ff.flip_y ? FAW'(yoff_prod) : '0;
            row_cnt_in = cmd_ff.height;
            col_cnt_in = cmd_ff.pairs;
            src_in     = IAW'(cmd_ff.image_offset);
            state_in   = ST_BASE;
         end
         ST_BASE: begin
            row_base_in = FAW'(cmd_ff.display_offset) + yoff_ff + xoff;
            pix_in      = row_base_in;
            if ((cmd_ff.pairs == '0) || (cmd_ff.height == '0)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_IMG;
            end
         end
         ST_IMG: begin
            img_re   = 1'b1;
            src_in   = src_ff + 1'b1;
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            frm_re   = 1'b1;
            state_in = ST_WR_HI;
         end
         ST_WR_HI: begin
            frm_we    = 1'b1;
            frm_wdata = frm_rd_ff ^ hi_nib;
            pix_in    = pix_ff + pix_step;
            state_in  = ST_RD_LO;
         end
         ST_RD_LO: begin
            frm_re   = 1'b1;
            state_in = ST_WR_LO;
         end
         ST_WR_LO: begin
            frm_we    = 1'b1;
            frm_wdata = frm_rd_ff ^ lo_nib;
            if ((col_cnt_ff == SW'(1)) && (row_cnt_ff == SW'(1))) begin
               state_in = ST_FINISH;
            end else begin
               // The next image byte is fetched while this pixel is written.
               img_re   = 1'b1;
               src_in   = src_ff + 1'b1;
               state_in = ST_RD_HI;
               if (col_cnt_ff == SW'(1)) begin
                  row_base_in = next_base;
                  pix_in      = next_base;
                  row_cnt_in  = row_cnt_ff - 1'b1;
                  col_cnt_in  = cmd_ff.pairs;
               end else begin
                  pix_in     = pix_ff + pix_step;
                  col_cnt_in = col_cnt_ff - 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (cmd_ff.func == xsb_pkg::FUNC_FRM_RD) ? frm_rd_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff      <= cmd_in;
      yoff_ff     <= yoff_in;
      row_base_ff <= row_base_in;
      pix_ff      <= pix_in;
      src_ff      <= src_in;
      row_cnt_ff  <= row_cnt_in;
      col_cnt_ff  <= col_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_addr] <= img_wdata;
      end
      if (img_re) begin
         img_rd_ff <= img_mem[img_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (frm_we) begin
         frm_mem[frm_addr] <= frm_wdata;
      end
      if (frm_re) begin
         frm_rd_ff <= frm_mem[frm_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/xor_sprite_blitter.sv =====
// XOR sprite blitter: a 4-bit-per-pixel sprite XORed into a byte-per-pixel frame.
// Top level; instantiates xsb_front, xsb_queue and xsb_engine, uses xsb_pkg.
//
// Every request word yields exactly one response word, in order. Image writes,
// frame writes and frame reads pass through an execute state and then a finish
// state. A draw passes through setup states, then for each image byte reads the
// byte and, for each of its two pixels, reads and then writes the frame pixel
// through the single port of the frame store, then posts the response.
// A two-word command queue lets new requests be taken while a draw runs and
// while a response waits. The row stride register resets to 320; the user must
// write it only while the block is idle; the block does not enforce this.
`default_nettype none

module xor_sprite_blitter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [xsb_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [xsb_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [xsb_pkg::DATA_W-1:0]     req_data,
   input  wire logic [xsb_pkg::IMG_OFS_W-1:0]  req_image_offset,
   input  wire logic [xsb_pkg::DISP_W-1:0]     req_display_offset,
   input  wire logic [xsb_pkg::SIDE_W-1:0]     req_width,
   input  wire logic [xsb_pkg::SIDE_W-1:0]     req_height,
   input  wire logic [xsb_pkg::FLIP_W-1:0]     req_flip,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [xsb_pkg::DATA_W-1:0]          rsp_read_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [xsb_pkg::STRIDE_W-1:0]   csr_wr_data
);

   logic [xsb_pkg::STRIDE_W-1:0] row_stride_ff;
   logic                         push;
   logic                         pop;
   logic                         queue_full;
   logic                         queue_empty;
   xsb_pkg::cmd_type             push_cmd;
   xsb_pkg::cmd_type             pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff <= xsb_pkg::STRIDE_RESET;
      end else if (csr_wr_en) begin
         row_stride_ff <= csr_wr_data;
      end
   end

   xsb_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_address        (req_address),
      .req_data           (req_data),
      .req_image_offset   (req_image_offset),
      .req_display_offset (req_display_offset),
      .req_width          (req_width),
      .req_height         (req_height),
      .req_flip           (req_flip),
      .queue_full         (queue_full),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   xsb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .pop_cmd  (pop_cmd)
   );

   xsb_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .pop_cmd       (pop_cmd),
      .pop           (pop),
      .row_stride    (row_stride_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data)
   );

endmodule

`default_nettype wire
